### design/grmc_pkg.sv
// Package for the gamepad robot mode controller.
// Holds the item structs, register indexes, mode codes and the stick scaling function.
// No dependencies.
package grmc_pkg;

    localparam int AXIS_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int HEIGHT_W   = 8;
    localparam int STEP_W     = 7;
    localparam int CYCLE_W    = 2;
    localparam int MODE_W     = 3;
    localparam int CMD_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_SHIFT = 12;
    localparam int PROD_W     = AXIS_W + GAIN_W + 2;
    localparam int QUO_W      = PROD_W - FRAC_SHIFT;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_STEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_MODES = 3'd6;

    // Register reset values.
    localparam logic [GAIN_W-1:0]          RST_LINEAR_GAIN = 16'd4096;
    localparam logic [GAIN_W-1:0]          RST_YAW_GAIN    = 16'd8192;
    localparam logic [GAIN_W-1:0]          RST_PITCH_GAIN  = 16'd2130;
    localparam logic signed [HEIGHT_W-1:0] RST_HEIGHT_MAX  = 8'sd4;
    localparam logic signed [HEIGHT_W-1:0] RST_HEIGHT_MIN  = -8'sd28;
    localparam logic [STEP_W-1:0]          RST_HEIGHT_STEP = 7'd2;
    localparam logic [CYCLE_W-1:0]         RST_CYCLE_MODES = 2'd3;

    // Locomotion modes. Modes zero to MODE_WALK_LAST are the walking modes.
    localparam logic [MODE_W-1:0] MODE_WALK_FIRST = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WALK_LAST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STAND_DOWN = 3'd5;
    localparam logic [MODE_W-1:0] MODE_STAND_UP   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_DAMPED     = 3'd7;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = 34'sd2048;
    localparam logic signed [QUO_W-1:0]  CMD_MAX    = 22'sd524287;
    localparam logic signed [QUO_W-1:0]  CMD_MIN    = -22'sd524288;

    typedef struct packed {
        logic                     btn_start;
        logic                     btn_a;
        logic                     btn_b;
        logic                     btn_lb;
        logic signed [AXIS_W-1:0] axis_fb;
        logic signed [AXIS_W-1:0] axis_lr;
        logic signed [AXIS_W-1:0] axis_yaw;
        logic signed [AXIS_W-1:0] axis_pitch;
        logic signed [AXIS_W-1:0] dpad_vertical;
    } t_in_item;

    typedef struct packed {
        logic [MODE_W-1:0]          mode_out;
        logic signed [HEIGHT_W-1:0] height_out;
        logic                       standing_out;
        logic signed [CMD_W-1:0]    vel_forward;
        logic signed [CMD_W-1:0]    vel_lateral;
        logic signed [CMD_W-1:0]    yaw_rate;
        logic signed [CMD_W-1:0]    pitch_angle;
    } t_out_item;

    // Previous levels of the START, A and B buttons and the d-pad directions, for press detection.
    typedef struct packed {
        logic down;
        logic up;
        logic b;
        logic a;
        logic start;
    } t_hist;

    // Q1.15 stick times unsigned Q4.12 gain, rounded half up to Q5.15 and saturated.
    function automatic logic signed [CMD_W-1:0] scale_axis(
        input logic signed [AXIS_W-1:0] axis,
        input logic [GAIN_W-1:0]        gain
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [QUO_W-1:0]  quo;
        prod = $signed(axis) * $signed({1'b0, gain});
        prod = prod + ROUND_HALF;
        quo  = prod[PROD_W-1:FRAC_SHIFT];
        if (quo > CMD_MAX) begin
            return CMD_MAX[CMD_W-1:0];
        end else if (quo < CMD_MIN) begin
            return CMD_MIN[CMD_W-1:0];
        end else begin
            return quo[CMD_W-1:0];
        end
    endfunction

endpackage

### design/gamepad_robot_mode_controller.sv
// Gamepad robot mode controller: an accepted input item waits in the input register
// and its result moves into the result register once that one is empty or drained.
// Throughput one report per cycle unless the receiver stalls; an input register feeds
// the mode logic and four stick multipliers, whose outputs land in a result register.
// Synchronous active-low reset clears both valid bits, the mode (walking mode zero),
// the height offset, the edge history, sets the standing flag, reloads the config.
// Depends on grmc_pkg.
module gamepad_robot_mode_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  grmc_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output grmc_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [grmc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [grmc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import grmc_pkg::*;

    // Configuration registers.
    logic [GAIN_W-1:0]          r_linear_gain;
    logic [GAIN_W-1:0]          r_yaw_gain;
    logic [GAIN_W-1:0]          r_pitch_gain;
    logic signed [HEIGHT_W-1:0] r_height_max;
    logic signed [HEIGHT_W-1:0] r_height_min;
    logic [STEP_W-1:0]          r_height_step;
    logic [CYCLE_W-1:0]         r_cycle_modes;

    // Controller state, updated as each report leaves the input register.
    logic [MODE_W-1:0]          r_mode, n_mode;
    logic                       r_standing, n_standing;
    logic signed [HEIGHT_W-1:0] r_height, n_height;
    t_hist                      r_hist, n_hist;

    // Input register and result register.
    t_in_item  r_in;
    logic      r_in_vld;
    t_out_item r_out, n_out;
    logic      r_out_vld;

    logic move;
    logic up_lvl, down_lvl;
    logic start_t, a_t, b_t, up_t, down_t;
    logic [CYCLE_W-1:0]      cyc_sum;
    logic signed [HEIGHT_W:0] h_up, h_down;

    // A report moves on when the result register is empty or being drained;
    // the input register refills in the same cycle, so reports stream back to back.
    assign move        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || move;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // Press detection: a level of one whose previous level was zero.
    assign up_lvl   = (r_in.dpad_vertical > 16'sd0);
    assign down_lvl = r_in.dpad_vertical[AXIS_W-1];
    assign start_t  = r_in.btn_start && !r_hist.start;
    assign a_t      = r_in.btn_a && !r_hist.a;
    assign b_t      = r_in.btn_b && !r_hist.b;
    assign up_t     = up_lvl && !r_hist.up;
    assign down_t   = down_lvl && !r_hist.down;

    // Walking mode cycle: the sum stays below twice the cycle count, so one
    // compare and subtract gives the modulo. A count of zero behaves as one.
    assign cyc_sum = r_mode[CYCLE_W-1:0] + 2'd1;
    assign h_up    = {r_height[HEIGHT_W-1], r_height} + $signed({2'b00, r_height_step});
    assign h_down  = {r_height[HEIGHT_W-1], r_height} - $signed({2'b00, r_height_step});

    always_comb begin
        n_mode     = r_mode;
        n_standing = r_standing;
        n_height   = r_height;
        n_hist     = '{down: down_lvl, up: up_lvl, b: r_in.btn_b,
                       a: r_in.btn_a, start: r_in.btn_start};

        // Events within one report are applied in a fixed order; later ones win.
        if (r_mode <= MODE_WALK_LAST) begin
            if (start_t) begin
                if (r_cycle_modes <= 2'd1) begin
                    n_mode = MODE_WALK_FIRST;
                end else if (cyc_sum >= r_cycle_modes) begin
                    n_mode = {1'b0, cyc_sum - r_cycle_modes};
                end else begin
                    n_mode = {1'b0, cyc_sum};
                end
                n_standing = 1'b1;
            end
            // Height moves clamp only on the side they move toward. Up and down
            // are never pressed in the same report, so both start from the
            // stored height.
            if (up_t) begin
                if (h_up > $signed({r_height_max[HEIGHT_W-1], r_height_max})) begin
                    n_height = r_height_max;
                end else begin
                    n_height = h_up[HEIGHT_W-1:0];
                end
                n_standing = 1'b1;
            end
            if (down_t) begin
                if (h_down < $signed({r_height_min[HEIGHT_W-1], r_height_min})) begin
                    n_height = r_height_min;
                end else begin
                    n_height = h_down[HEIGHT_W-1:0];
                end
                n_standing = 1'b1;
            end
            if (r_in.btn_lb && a_t) begin
                n_mode     = MODE_STAND_UP;
                n_standing = 1'b1;
            end
        end else if (r_mode == MODE_STAND_DOWN) begin
            if ((r_in.btn_lb && a_t) || start_t) begin
                n_mode     = MODE_STAND_UP;
                n_standing = 1'b1;
            end
            if (r_in.btn_lb && b_t) begin
                n_mode     = MODE_DAMPED;
                n_standing = 1'b0;
            end
        end else if (r_mode == MODE_STAND_UP) begin
            if (r_in.btn_lb && a_t) begin
                n_mode     = MODE_STAND_DOWN;
                n_standing = 1'b0;
            end
            if (start_t) begin
                n_mode     = MODE_WALK_FIRST;
                n_standing = 1'b1;
            end
        end else if (r_mode == MODE_DAMPED) begin
            if (start_t) begin
                n_mode     = MODE_STAND_DOWN;
                n_standing = 1'b0;
            end
            // Leaving damping goes to the posture opposite the current flag.
            if (r_in.btn_lb && a_t) begin
                n_mode     = n_standing ? MODE_STAND_DOWN : MODE_STAND_UP;
                n_standing = 1'b1;
            end
        end
        // Modes three and four are never entered and hold under every button.

        n_out.mode_out     = n_mode;
        n_out.height_out   = n_height;
        n_out.standing_out = n_standing;
        n_out.vel_forward  = scale_axis(r_in.axis_fb, r_linear_gain);
        n_out.vel_lateral  = scale_axis(r_in.axis_lr, r_linear_gain);
        n_out.yaw_rate     = scale_axis(r_in.axis_yaw, r_yaw_gain);
        n_out.pitch_angle  = scale_axis(r_in.axis_pitch, r_pitch_gain);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear_gain <= RST_LINEAR_GAIN;
            r_yaw_gain    <= RST_YAW_GAIN;
            r_pitch_gain  <= RST_PITCH_GAIN;
            r_height_max  <= RST_HEIGHT_MAX;
            r_height_min  <= RST_HEIGHT_MIN;
            r_height_step <= RST_HEIGHT_STEP;
            r_cycle_modes <= RST_CYCLE_MODES;
            r_mode        <= MODE_WALK_FIRST;
            r_standing    <= 1'b1;
            r_height      <= '0;
            r_hist        <= '0;
            r_in_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LINEAR_GAIN: r_linear_gain <= i_cfg_data[GAIN_W-1:0];
                    CFG_YAW_GAIN:    r_yaw_gain    <= i_cfg_data[GAIN_W-1:0];
                    CFG_PITCH_GAIN:  r_pitch_gain  <= i_cfg_data[GAIN_W-1:0];
                    CFG_HEIGHT_MAX:  r_height_max  <= $signed(i_cfg_data[HEIGHT_W-1:0]);
                    CFG_HEIGHT_MIN:  r_height_min  <= $signed(i_cfg_data[HEIGHT_W-1:0]);
                    CFG_HEIGHT_STEP: r_height_step <= i_cfg_data[STEP_W-1:0];
                    CFG_CYCLE_MODES: r_cycle_modes <= i_cfg_data[CYCLE_W-1:0];
                    default: ;
                endcase
            end
            if (move) begin
                r_mode     <= n_mode;
                r_standing <= n_standing;
                r_height   <= n_height;
                r_hist     <= n_hist;
            end
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (move) begin
            r_out <= n_out;
        end
    end

endmodule

### dv/testbench.sv
// Self-checking testbench for the gamepad robot mode controller.
// Streams gamepad report items through the block and checks every result item
// against an in-house model of the mode machine and stick scaling. Uses grmc_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import grmc_pkg::*;

    // Run length guard, far above the slowest legal run.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 240;
    // Cycles to wait after the last result before changing registers or ending.
    localparam int SETTLE_CYCLES = 6;

    // Button masks for the directed items, ordered {START, A, B, LB}.
    localparam logic [3:0] BTN_NONE  = 4'b0000;
    localparam logic [3:0] BTN_START = 4'b1000;
    localparam logic [3:0] BTN_A     = 4'b0100;
    localparam logic [3:0] BTN_B     = 4'b0010;
    localparam logic [3:0] BTN_LB    = 4'b0001;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_STALLS} rx_pattern_e;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Items waiting to be driven, and result items predicted but not yet seen.
    t_in_item  pending_reports[$];
    t_out_item expected_cmds[$];

    // The monitor records each input handshake here for the driver to see.
    bit in_fire = 1'b0;

    int err_count    = 0;
    int result_count = 0;
    int cycle_count  = 0;

    // Sender burst shaping.
    int burst_left = 1;
    int gap_left   = 0;

    // Receiver stall pattern.
    rx_pattern_e rx_pattern = RX_OPEN;
    int          rx_left    = 0;
    int          rx_run     = 0;
    bit          rx_low     = 1'b0;

    // Model copy of the configuration registers.
    logic [GAIN_W-1:0]          lin_gain_m;
    logic [GAIN_W-1:0]          yaw_gain_m;
    logic [GAIN_W-1:0]          pitch_gain_m;
    logic signed [HEIGHT_W-1:0] hmax_m;
    logic signed [HEIGHT_W-1:0] hmin_m;
    logic [STEP_W-1:0]          step_m;
    logic [CYCLE_W-1:0]         cycles_m;

    // Model copy of the block state.
    logic [MODE_W-1:0]          mode_m;
    logic                       standing_m;
    logic signed [HEIGHT_W-1:0] height_m;
    t_hist                      hist_m;

    // Directed items walk the sticks through this list of extreme, half-scale and near-zero values.
    logic signed [AXIS_W-1:0] stick_corners [8] = '{
        16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff,
        16'sh0001, 16'sh8001, 16'sh4000, 16'shbfff
    };
    int corner_idx = 0;

    gamepad_robot_mode_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Stick times gain in Q4.12, plus half an output LSB, then floor by the
    // arithmetic shift. The result saturates to the 20-bit command range.
    function automatic logic signed [CMD_W-1:0] scale_stick(
        input logic signed [AXIS_W-1:0] stick,
        input logic [GAIN_W-1:0]        gain
    );
        longint prod;
        longint quo;
        prod = longint'(stick) * longint'(gain) + 64'sd2048;
        quo  = prod >>> 12;
        if (quo > 64'sd524287) begin
            quo = 64'sd524287;
        end else if (quo < -64'sd524288) begin
            quo = -64'sd524288;
        end
        return quo[CMD_W-1:0];
    endfunction

    // Advances the model by one report item and returns the command item that
    // the block must produce for it.
    function automatic t_out_item predict_command(input t_in_item rep);
        logic      up;
        logic      dn;
        logic      start_t;
        logic      a_t;
        logic      b_t;
        logic      up_t;
        logic      dn_t;
        int        h;
        int        n;
        t_out_item res;

        // The d-pad counts as up for any positive value, down for any negative.
        up = !rep.dpad_vertical[AXIS_W-1] && (rep.dpad_vertical != '0);
        dn = rep.dpad_vertical[AXIS_W-1];

        // A press is a level of one after a level of zero.
        start_t = rep.btn_start && !hist_m.start;
        a_t     = rep.btn_a && !hist_m.a;
        b_t     = rep.btn_b && !hist_m.b;
        up_t    = up && !hist_m.up;
        dn_t    = dn && !hist_m.down;

        hist_m.start = rep.btn_start;
        hist_m.a     = rep.btn_a;
        hist_m.b     = rep.btn_b;
        hist_m.up    = up;
        hist_m.down  = dn;

        // Events are applied in a fixed order, so a later one overrides an
        // earlier one within the same report.
        if (mode_m <= MODE_WALK_LAST) begin
            if (start_t) begin
                // A cycle count of zero behaves as one.
                n          = (cycles_m == '0) ? 1 : int'(cycles_m);
                mode_m     = MODE_W'((int'(mode_m) + 1) % n);
                standing_m = 1'b1;
            end
            if (up_t) begin
                // Raising clamps only at the upper limit.
                h          = int'(height_m) + int'(step_m);
                height_m   = (h > int'(hmax_m)) ? hmax_m : HEIGHT_W'(h);
                standing_m = 1'b1;
            end
            if (dn_t) begin
                // Lowering clamps only at the lower limit.
                h          = int'(height_m) - int'(step_m);
                height_m   = (h < int'(hmin_m)) ? hmin_m : HEIGHT_W'(h);
                standing_m = 1'b1;
            end
            if (rep.btn_lb && a_t) begin
                mode_m     = MODE_STAND_UP;
                standing_m = 1'b1;
            end
        end else if (mode_m == MODE_STAND_DOWN) begin
            if ((rep.btn_lb && a_t) || start_t) begin
                mode_m     = MODE_STAND_UP;
                standing_m = 1'b1;
            end
            if (rep.btn_lb && b_t) begin
                mode_m     = MODE_DAMPED;
                standing_m = 1'b0;
            end
        end else if (mode_m == MODE_STAND_UP) begin
            if (rep.btn_lb && a_t) begin
                mode_m     = MODE_STAND_DOWN;
                standing_m = 1'b0;
            end
            if (start_t) begin
                mode_m     = MODE_WALK_FIRST;
                standing_m = 1'b1;
            end
        end else if (mode_m == MODE_DAMPED) begin
            if (start_t) begin
                mode_m     = MODE_STAND_DOWN;
                standing_m = 1'b0;
            end
            if (rep.btn_lb && a_t) begin
                mode_m     = standing_m ? MODE_STAND_DOWN : MODE_STAND_UP;
                standing_m = 1'b1;
            end
        end

        res.mode_out     = mode_m;
        res.height_out   = height_m;
        res.standing_out = standing_m;
        res.vel_forward  = scale_stick(rep.axis_fb, lin_gain_m);
        res.vel_lateral  = scale_stick(rep.axis_lr, lin_gain_m);
        res.yaw_rate     = scale_stick(rep.axis_yaw, yaw_gain_m);
        res.pitch_angle  = scale_stick(rep.axis_pitch, pitch_gain_m);
        return res;
    endfunction

    // Stick values lean toward the extremes and the area around zero.
    function automatic logic signed [AXIS_W-1:0] random_stick();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 4)) - 16'sd2;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR at %0t ns, result %0d: %s is %0d, expected %0d",
                 $time, result_count, what, got, want);
        err_count++;
    endtask

    // Queues one directed item; the sticks step through the corner list.
    task automatic push_report(input logic [3:0] btns, input logic signed [AXIS_W-1:0] dpad);
        t_in_item rep;
        rep.btn_start     = btns[3];
        rep.btn_a         = btns[2];
        rep.btn_b         = btns[1];
        rep.btn_lb        = btns[0];
        rep.axis_fb       = stick_corners[corner_idx % 8];
        rep.axis_lr       = stick_corners[(corner_idx + 3) % 8];
        rep.axis_yaw      = stick_corners[(corner_idx + 5) % 8];
        rep.axis_pitch    = stick_corners[(corner_idx + 6) % 8];
        rep.dpad_vertical = dpad;
        corner_idx++;
        pending_reports.push_back(rep);
    endtask

    // Blocks until the sender is idle and every predicted result has arrived.
    task automatic drain();
        while (pending_reports.size() != 0 || in_valid || expected_cmds.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
    endtask

    // Writes all seven registers back to back, with junk in the unused upper
    // data bits, and mirrors the new values into the model.
    task automatic apply_settings(
        input logic [GAIN_W-1:0]          lin,
        input logic [GAIN_W-1:0]          yaw,
        input logic [GAIN_W-1:0]          pitch,
        input logic signed [HEIGHT_W-1:0] hmax,
        input logic signed [HEIGHT_W-1:0] hmin,
        input logic [STEP_W-1:0]          step,
        input logic [CYCLE_W-1:0]         cyc
    );
        write_reg(CFG_LINEAR_GAIN, lin);
        write_reg(CFG_YAW_GAIN, yaw);
        write_reg(CFG_PITCH_GAIN, pitch);
        write_reg(CFG_HEIGHT_MAX, {8'($urandom), hmax});
        write_reg(CFG_HEIGHT_MIN, {8'($urandom), hmin});
        write_reg(CFG_HEIGHT_STEP, {9'($urandom), step});
        write_reg(CFG_CYCLE_MODES, {14'($urandom), cyc});
        @(negedge i_clk);
        cfg_we       <= 1'b0;
        lin_gain_m   = lin;
        yaw_gain_m   = yaw;
        pitch_gain_m = pitch;
        hmax_m       = hmax;
        hmin_m       = hmin;
        step_m       = step;
        cycles_m     = cyc;
    endtask

    // Driver: presents report items at the falling edge in bursts of random
    // length separated by random gaps. A presented item is held until the
    // monitor has seen it accepted.
    always @(negedge i_clk) begin : drive_reports
        logic     next_valid;
        t_in_item next_item;
        next_valid = in_valid;
        next_item  = in_item;
        if (!in_valid || in_fire) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reports.size() != 0) begin
                next_item  = pending_reports.pop_front();
                next_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // About a quarter of the bursts run straight into the next.
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        in_valid <= next_valid;
        in_item  <= next_item;
    end

    // Receiver: out_ready follows a pattern that is redrawn at random intervals:
    // always ready, mostly ready, rarely ready, or long stalls.
    always @(negedge i_clk) begin : drive_ready
        if (rx_left == 0) begin
            rx_pattern = rx_pattern_e'($urandom_range(0, 3));
            rx_left    = $urandom_range(64, 256);
        end else begin
            rx_left--;
        end
        case (rx_pattern)
            RX_OPEN: begin
                out_ready <= 1'b1;
            end
            RX_MOSTLY: begin
                out_ready <= ($urandom_range(0, 3) != 0);
            end
            RX_SPARSE: begin
                out_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                if (rx_run == 0) begin
                    rx_low = !rx_low;
                    rx_run = rx_low ? $urandom_range(1, 30) : $urandom_range(1, 10);
                end else begin
                    rx_run--;
                end
                out_ready <= !rx_low;
            end
        endcase
    end

    // Monitor: at each rising edge checks an accepted result item against the
    // oldest prediction, then predicts the result of an accepted report item.
    always @(posedge i_clk) begin : watch_ports
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_cmds.size() == 0) begin
                report_mismatch("unexpected result item, mode_out", out_item.mode_out, -1);
            end else begin
                want = expected_cmds.pop_front();
                if (out_item.mode_out !== want.mode_out)
                    report_mismatch("mode_out", out_item.mode_out, want.mode_out);
                if (out_item.height_out !== want.height_out)
                    report_mismatch("height_out", out_item.height_out, want.height_out);
                if (out_item.standing_out !== want.standing_out)
                    report_mismatch("standing_out", out_item.standing_out, want.standing_out);
                if (out_item.vel_forward !== want.vel_forward)
                    report_mismatch("vel_forward", out_item.vel_forward, want.vel_forward);
                if (out_item.vel_lateral !== want.vel_lateral)
                    report_mismatch("vel_lateral", out_item.vel_lateral, want.vel_lateral);
                if (out_item.yaw_rate !== want.yaw_rate)
                    report_mismatch("yaw_rate", out_item.yaw_rate, want.yaw_rate);
                if (out_item.pitch_angle !== want.pitch_angle)
                    report_mismatch("pitch_angle", out_item.pitch_angle, want.pitch_angle);
            end
            result_count++;
        end
        in_fire = i_rst_n && in_valid && in_ready;
        if (in_fire) begin
            expected_cmds.push_back(predict_command(in_item));
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d result items still expected",
                     cycle_count, expected_cmds.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_item                 rep;
        logic                     lv_start;
        logic                     lv_a;
        logic                     lv_b;
        logic [GAIN_W-1:0]        g_lin;
        logic [GAIN_W-1:0]        g_yaw;
        logic [GAIN_W-1:0]        g_pitch;
        logic signed [HEIGHT_W-1:0] s_hmax;
        logic signed [HEIGHT_W-1:0] s_hmin;
        logic [STEP_W-1:0]        s_step;
        logic [CYCLE_W-1:0]       s_cyc;

        // Model state and registers as they come out of reset.
        lin_gain_m   = RST_LINEAR_GAIN;
        yaw_gain_m   = RST_YAW_GAIN;
        pitch_gain_m = RST_PITCH_GAIN;
        hmax_m       = RST_HEIGHT_MAX;
        hmin_m       = RST_HEIGHT_MIN;
        step_m       = RST_HEIGHT_STEP;
        cycles_m     = RST_CYCLE_MODES;
        mode_m       = MODE_WALK_FIRST;
        standing_m   = 1'b1;
        height_m     = '0;
        hist_m       = '0;
        lv_start     = 1'b0;
        lv_a         = 1'b0;
        lv_b         = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items under the reset settings. START first walks the
        // three walking modes and wraps to zero.
        push_report(BTN_NONE, 16'sd0);
        push_report(BTN_START, 16'sd0);
        push_report(BTN_START, 16'sd0);
        push_report(BTN_NONE, 16'sd0);
        push_report(BTN_START, 16'sd0);
        push_report(BTN_NONE, 16'sd0);
        push_report(BTN_START, 16'sd0);
        // D-pad up steps the height, holding it does nothing, and the upper
        // limit clamps; then one step down from the most negative value.
        push_report(BTN_NONE, 16'sd1);
        push_report(BTN_NONE, 16'sh7fff);
        push_report(BTN_NONE, 16'sd0);
        push_report(BTN_NONE, 16'sd100);
        push_report(BTN_NONE, 16'sd0);
        push_report(BTN_NONE, 16'sd5);
        push_report(BTN_NONE, 16'sh8000);
        push_report(BTN_NONE, 16'sd0);
        // LB with A stands up, and again stands down; START leaves stand-down.
        push_report(BTN_LB | BTN_A, 16'sd0);
        push_report(BTN_LB, 16'sd0);
        push_report(BTN_LB | BTN_A, 16'sd0);
        push_report(BTN_START, 16'sd0);
        push_report(BTN_LB | BTN_A, 16'sd0);
        // LB with B enters damped mode, START goes back to stand-down, and
        // LB with A in damped mode picks its target from the standing flag.
        push_report(BTN_LB | BTN_B, 16'sd0);
        push_report(BTN_START, 16'sd0);
        push_report(BTN_LB | BTN_B, 16'sd0);
        push_report(BTN_LB | BTN_A, 16'sd0);
        push_report(BTN_START, 16'sd0);
        push_report(BTN_NONE, 16'sd0);
        // Several events in one walking-mode report: the stand-up wins.
        push_report(BTN_START | BTN_LB | BTN_A, -16'sd1);
        push_report(BTN_NONE, 16'sd0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            // Each phase starts with the block idle, so every phase boundary
            // also holds the sender until all results are in.
            drain();
            case (p)
                0: begin
                    apply_settings(16'd0, 16'd0, 16'd0, 8'sd127, -8'sd128, 7'd127, 2'd0);
                end
                1: begin
                    apply_settings(16'hffff, 16'hffff, 16'hffff, -8'sd128, 8'sd127, 7'd0, 2'd1);
                end
                2: begin
                    apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                   8'sd10, -8'sd10, 7'd3, 2'd2);
                end
                3: begin
                    apply_settings(RST_LINEAR_GAIN, RST_YAW_GAIN, RST_PITCH_GAIN,
                                   RST_HEIGHT_MAX, RST_HEIGHT_MIN, RST_HEIGHT_STEP,
                                   RST_CYCLE_MODES);
                end
                default: begin
                    g_lin   = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
                    g_yaw   = 16'($urandom);
                    g_pitch = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
                    s_hmax  = 8'($urandom);
                    s_hmin  = 8'($urandom);
                    s_step  = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 8))
                                                          : 7'($urandom);
                    s_cyc   = 2'($urandom);
                    apply_settings(g_lin, g_yaw, g_pitch, s_hmax, s_hmin, s_step, s_cyc);
                end
            endcase

            // Button levels toggle now and then so that presses, holds and
            // releases all occur; LB is random so LB combinations come often.
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: all levels scrambled at once.
                    lv_start = 1'($urandom);
                    lv_a     = 1'($urandom);
                    lv_b     = 1'($urandom);
                end else begin
                    if ($urandom_range(0, 2) == 0) lv_start = !lv_start;
                    if ($urandom_range(0, 2) == 0) lv_a = !lv_a;
                    if ($urandom_range(0, 2) == 0) lv_b = !lv_b;
                end
                rep.btn_start  = lv_start;
                rep.btn_a      = lv_a;
                rep.btn_b      = lv_b;
                rep.btn_lb     = 1'($urandom);
                rep.axis_fb    = random_stick();
                rep.axis_lr    = random_stick();
                rep.axis_yaw   = random_stick();
                rep.axis_pitch = random_stick();
                case ($urandom_range(0, 5))
                    0, 1: rep.dpad_vertical = 16'sd0;
                    2: rep.dpad_vertical = 16'($urandom_range(1, 32767));
                    3: rep.dpad_vertical = 16'sh8000 | 16'($urandom);
                    4: rep.dpad_vertical = 16'($urandom);
                    default: rep.dpad_vertical = 16'($urandom_range(0, 2)) - 16'sd1;
                endcase
                pending_reports.push_back(rep);
            end
        end

        drain();
        if (expected_cmds.size() != 0) begin
            report_mismatch("result items never delivered", 0, expected_cmds.size());
        end
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### gamepad_robot_mode_controller.f
design/grmc_pkg.sv
design/gamepad_robot_mode_controller.sv
dv/testbench.sv
